// File: rtl/assert_macros.svh
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/fwdk_pkg.sv
// types and constants for the keyed-delete fifo
package fwdk_pkg;

    localparam int ROOM_W   = 16;
    localparam int CLIENT_W = 16;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic [ROOM_W-1:0]   room;
        logic [CLIENT_W-1:0] client;
    } entry_t;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [ROOM_W-1:0]   room_id;
        logic [CLIENT_W-1:0] client_key;
    } req_t;

    typedef struct packed {
        logic [ROOM_W-1:0]   removed_room;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
        logic                is_empty;
    } res_t;

endpackage

// File: rtl/fifo_with_delete_by_key.sv
// top level: keyed-delete fifo with its scan and shift sequencer
// enqueue, unknown codes and requests on an empty queue answer in the cycle after the request;
//   dequeue and delete answer once the scan has read and compared every occupied slot
// start is ignored while busy, which lasts through the one-read-per-cycle scan
// reset clears the count and the sequencer; entry contents need no clearing
// results come on a one-cycle done strobe and cannot be stalled
`include "assert_macros.svh"

module fifo_with_delete_by_key #(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  fwdk_pkg::req_t   req,
    output logic             busy,
    output logic             done,
    output fwdk_pkg::res_t   result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    fwdk_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                 occ_reg, occ_next;
    logic [CW-1:0]                 rd_idx_reg, rd_idx_next;
    logic                          vld_reg, vld_next;
    logic                          found_reg, found_next;
    logic                          done_reg, done_next;
    logic [AW-1:0]                 dat_idx_reg, dat_idx_next;
    logic [fwdk_pkg::OP_W-1:0]     op_reg, op_next;
    logic [fwdk_pkg::CLIENT_W-1:0] key_reg, key_next;
    logic [fwdk_pkg::ROOM_W-1:0]   hit_room_reg, hit_room_next;
    fwdk_pkg::res_t                res_reg, res_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    fwdk_pkg::entry_t    ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    fwdk_pkg::entry_t    ram_rdata;

    logic accept;
    logic last;
    logic hit;
    logic is_scan_op;
    logic full_reported;

    fwdk_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy       = (state_reg != fwdk_pkg::S_IDLE);
    assign accept     = start && !busy;
    assign is_scan_op = (req.operation == fwdk_pkg::OP_DEQ) ||
                        (req.operation == fwdk_pkg::OP_DEL);
    // a dequeue takes the head, so it matches whatever sits in slot 0
    assign hit  = (op_reg == fwdk_pkg::OP_DEQ) || (ram_rdata.client == key_reg);
    assign last = vld_reg && (CW'(dat_idx_reg) == occ_reg - CW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fwdk_pkg::S_IDLE:
            begin
                if (accept && is_scan_op && (occ_reg != '0))
                begin
                    state_next = fwdk_pkg::S_SCAN;
                end
            end
            fwdk_pkg::S_SCAN:
            begin
                if (last)
                begin
                    state_next = fwdk_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fwdk_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        occ_next      = occ_reg;
        rd_idx_next   = rd_idx_reg;
        vld_next      = 1'b0;
        found_next    = found_reg;
        done_next     = 1'b0;
        dat_idx_next  = dat_idx_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        hit_room_next = hit_room_reg;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = ram_rdata;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        unique case (state_reg)
            fwdk_pkg::S_IDLE:
            begin
                rd_idx_next   = '0;
                found_next    = 1'b0;
                hit_room_next = '0;
                if (accept)
                begin
                    op_next               = req.operation;
                    key_next              = req.client_key;
                    done_next             = 1'b1;
                    res_next.removed_room = '0;
                    res_next.status       = fwdk_pkg::ST_MISS;
                    res_next.entry_count  = fwdk_pkg::COUNT_W'(occ_reg);
                    res_next.is_empty     = (occ_reg == '0);
                    case (req.operation) inside
                        fwdk_pkg::OP_ENQ:
                        begin
                            if (occ_reg == CW'(DEPTH))
                            begin
                                res_next.status = fwdk_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we                = 1'b1;
                                ram_waddr             = occ_reg[AW-1:0];
                                ram_wdata.room        = req.room_id;
                                ram_wdata.client      = req.client_key;
                                occ_next              = occ_reg + CW'(1);
                                res_next.status       = fwdk_pkg::ST_DONE;
                                res_next.entry_count  =
                                    fwdk_pkg::COUNT_W'(occ_reg + CW'(1));
                                res_next.is_empty     = 1'b0;
                            end
                        end
                        fwdk_pkg::OP_DEQ, fwdk_pkg::OP_DEL:
                        begin
                            // nonempty: the result comes at the end of the scan
                            if (occ_reg != '0)
                            begin
                                done_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            res_next.status = fwdk_pkg::ST_MISS;
                        end
                    endcase
                end
            end
            fwdk_pkg::S_SCAN:
            begin
                // read side runs one slot ahead of the compare and shift side
                if (rd_idx_reg < occ_reg)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = rd_idx_reg[AW-1:0];
                    rd_idx_next  = rd_idx_reg + CW'(1);
                    vld_next     = 1'b1;
                    dat_idx_next = rd_idx_reg[AW-1:0];
                end
                if (vld_reg)
                begin
                    if (found_reg)
                    begin
                        // close the gap: move this entry down one slot
                        ram_we    = 1'b1;
                        ram_waddr = dat_idx_reg - AW'(1);
                        ram_wdata = ram_rdata;
                    end
                    else if (hit)
                    begin
                        found_next    = 1'b1;
                        hit_room_next = ram_rdata.room;
                    end
                end
                if (last)
                begin
                    done_next = 1'b1;
                    if (found_reg || hit)
                    begin
                        occ_next              = occ_reg - CW'(1);
                        res_next.removed_room = found_reg ? hit_room_reg : ram_rdata.room;
                        res_next.status       = fwdk_pkg::ST_DONE;
                        res_next.entry_count  = fwdk_pkg::COUNT_W'(occ_reg - CW'(1));
                        res_next.is_empty     = (occ_reg == CW'(1));
                    end
                    else
                    begin
                        res_next.removed_room = '0;
                        res_next.status       = fwdk_pkg::ST_MISS;
                        res_next.entry_count  = fwdk_pkg::COUNT_W'(occ_reg);
                        res_next.is_empty     = 1'b0;
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= fwdk_pkg::S_IDLE;
            occ_reg    <= '0;
            rd_idx_reg <= '0;
            vld_reg    <= 1'b0;
            found_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            rd_idx_reg <= rd_idx_next;
            vld_reg    <= vld_next;
            found_reg  <= found_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dat_idx_reg  <= dat_idx_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        hit_room_reg <= hit_room_next;
        res_reg      <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    assign full_reported = done_reg && (res_reg.status == fwdk_pkg::ST_FULL);

    `ASSERT_IMPLIES(a_occ_bound, 1'b1, occ_reg <= CW'(DEPTH))
    `ASSERT_IMPLIES(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr)
    `ASSERT_NEXT(a_scan_ends_in_result, (state_reg == fwdk_pkg::S_SCAN) && last, done_reg)
    `ASSERT_IMPLIES(a_full_only_at_depth, full_reported, occ_reg == CW'(DEPTH))

endmodule

// File: rtl/fwdk_ram.sv
// entry storage: one write port, one registered read port
module fwdk_ram #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  fwdk_pkg::entry_t  wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output fwdk_pkg::entry_t  rdata
);

    fwdk_pkg::entry_t mem [DEPTH];
    fwdk_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
